### rtl/core/sseg_pkg.sv
// Shared constants, command codes and controller/datapath interface types
// for the seven-segment write sequencer. No dependencies.
package sseg_pkg;

    localparam int DIGIT_COUNT = 8;

    localparam int IDX_W = 3;
    localparam int CNT_W = 4;

    localparam logic [2:0] MODE_RAW   = 3'd0;
    localparam logic [2:0] MODE_HEX   = 3'd1;
    localparam logic [2:0] MODE_HEX16 = 3'd2;
    localparam logic [2:0] MODE_HEX8  = 3'd3;
    localparam logic [2:0] MODE_DEC16 = 3'd4;
    localparam logic [2:0] MODE_CLEAR = 3'd5;

    localparam logic [7:0] CTRL_RAW = 8'h70;
    localparam logic [7:0] CTRL_HEX = 8'h50;
    localparam logic [7:0] DP_DARK  = 8'h80;
    localparam logic [7:0] PAT_E    = 8'hCF;
    localparam logic [7:0] PAT_N    = 8'hFA;
    localparam logic [7:0] PAT_O    = 8'hFB;

    localparam logic [15:0] DEC_MAX = 16'd9999;
    // floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for every 16-bit x.
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef struct packed {
        logic             load;      // latch the command on the input ports
        logic             ctrl_step; // control byte goes out this cycle
        logic             advance;   // data byte done, move to next digit write
        logic             sel_data;  // drive the data byte, else the control byte
        logic [IDX_W-1:0] idx;       // digit write within the command
    } cmd_t;

    typedef struct packed {
        logic no_op;    // command on the ports causes no transfer
        logic final_wr; // current digit write is the last of the command
    } status_t;

    // Reduce a digit address modulo DIGIT_COUNT (at most four subtractions).
    function automatic logic [IDX_W-1:0] digit_mod(input logic [2:0] x);
        logic [3:0] a;
        a = {1'b0, x};
        for (int i = 0; i < 4; i++)
        begin
            if (a >= 4'(DIGIT_COUNT))
                a = a - 4'(DIGIT_COUNT);
        end
        return a[IDX_W-1:0];
    endfunction

endpackage

### rtl/core/sseg_ctrl.sv
// Sequencer state machine: steps through the digit writes of a command,
// one control transfer and one data transfer each. Uses sseg_pkg.
module sseg_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  sseg_pkg::status_t        status,
    output sseg_pkg::cmd_t           cmd,
    output logic                     busy,
    output logic                     strobe,
    output logic                     mode_pin,
    output logic                     last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CTRL = 2'd1;
    localparam logic [1:0] S_DATA = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [sseg_pkg::IDX_W-1:0]   idx_reg, idx_next;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd.load      = 1'b0;
        cmd.ctrl_step = 1'b0;
        cmd.advance   = 1'b0;
        cmd.sel_data  = 1'b0;
        cmd.idx       = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    idx_next = '0;
                    if (!status.no_op)
                        state_next = S_CTRL;
                end
            end
            S_CTRL:
            begin
                cmd.ctrl_step = 1'b1;
                state_next    = S_DATA;
            end
            S_DATA:
            begin
                cmd.sel_data = 1'b1;
                if (status.final_wr)
                    state_next = S_IDLE;
                else
                begin
                    cmd.advance = 1'b1;
                    idx_next    = idx_reg + 1'b1;
                    state_next  = S_CTRL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign strobe   = (state_reg == S_CTRL) || (state_reg == S_DATA);
    assign mode_pin = (state_reg == S_CTRL);
    assign last     = (state_reg == S_DATA) && status.final_wr;

endmodule

### rtl/core/sseg_dp.sv
// Datapath: holds the command, extracts hex nibbles and decimal digits,
// and forms the control and data bytes for each digit write. Uses sseg_pkg.
module sseg_dp (
    input  logic               clk,
    input  logic [2:0]         mode,
    input  logic [2:0]         digit_addr,
    input  logic [15:0]        value,
    input  logic               dp_on,
    input  logic [1:0]         line,
    input  sseg_pkg::cmd_t     cmd,
    output sseg_pkg::status_t  status,
    output logic [7:0]         bus_byte
);

    logic [2:0]  mode_reg;
    logic [2:0]  addr_reg;
    logic [15:0] val_reg;
    logic        dp_reg;
    logic        half_reg;
    logic        over_reg;
    logic        bad_reg;
    logic [3:0]  digit_reg;

    logic [29:0] prod;
    logic [9:0]  quot;
    logic [3:0]  rem;

    logic [sseg_pkg::IDX_W-1:0] a0, a1, wr_addr;
    logic [3:0]                 a1_sum;
    logic [2:0]                 err_idx;
    logic [sseg_pkg::CNT_W-1:0] wr_count;
    logic [7:0]                 ctrl_base, data_byte;

    // Decimal digits come out least significant first, one per digit write.
    assign prod = {16'd0, val_reg[13:0]} * {14'd0, sseg_pkg::DIV10_MUL};
    assign quot = prod[sseg_pkg::DIV10_SHIFT +: 10];
    assign rem  = 4'(val_reg[13:0] - ({4'd0, quot} * 14'd10));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            addr_reg <= digit_addr;
            val_reg  <= value;
            dp_reg   <= dp_on;
            half_reg <= line[0];
            over_reg <= (value > sseg_pkg::DEC_MAX);
            bad_reg  <= (line > 2'd1);
        end
        else if (cmd.ctrl_step && mode_reg == sseg_pkg::MODE_DEC16)
        begin
            digit_reg <= rem;
            val_reg   <= {6'd0, quot};
        end
        else if (cmd.advance && mode_reg != sseg_pkg::MODE_DEC16)
        begin
            val_reg <= {4'd0, val_reg[15:4]};
        end
    end

    assign a0     = sseg_pkg::digit_mod(addr_reg);
    assign a1_sum = {1'b0, a0} + 4'd1;
    assign a1     = (a1_sum == 4'(sseg_pkg::DIGIT_COUNT)) ? '0 : a1_sum[sseg_pkg::IDX_W-1:0];
    // Error writes: E on digits 0..2 when over range, then n and o on a bad line.
    assign err_idx = over_reg ? cmd.idx : cmd.idx + 3'd3;

    always_comb
    begin
        ctrl_base = sseg_pkg::CTRL_HEX;
        wr_addr   = cmd.idx;
        data_byte = sseg_pkg::DP_DARK | {4'd0, val_reg[3:0]};
        wr_count  = 4'd1;
        case (mode_reg)
            sseg_pkg::MODE_RAW:
            begin
                ctrl_base = sseg_pkg::CTRL_RAW;
                wr_addr   = addr_reg;
                data_byte = val_reg[7:0];
            end
            sseg_pkg::MODE_HEX:
            begin
                wr_addr   = addr_reg;
                data_byte = {~dp_reg, val_reg[6:0]};
            end
            sseg_pkg::MODE_HEX16:
            begin
                wr_addr  = {half_reg, 2'd3 - cmd.idx[1:0]};
                wr_count = 4'd4;
            end
            sseg_pkg::MODE_HEX8:
            begin
                wr_addr  = cmd.idx[0] ? a1 : a0;
                wr_count = 4'd2;
            end
            sseg_pkg::MODE_DEC16:
            begin
                if (over_reg || bad_reg)
                begin
                    ctrl_base = sseg_pkg::CTRL_RAW;
                    wr_count  = (over_reg ? 4'd3 : 4'd0) + (bad_reg ? 4'd2 : 4'd0);
                    if (err_idx < 3'd3)
                    begin
                        wr_addr   = err_idx;
                        data_byte = sseg_pkg::PAT_E;
                    end
                    else if (err_idx == 3'd3)
                    begin
                        wr_addr   = 3'd0;
                        data_byte = sseg_pkg::PAT_N;
                    end
                    else
                    begin
                        wr_addr   = 3'd5;
                        data_byte = sseg_pkg::PAT_O;
                    end
                end
                else
                begin
                    wr_addr   = {half_reg, 2'd3 - cmd.idx[1:0]};
                    data_byte = sseg_pkg::DP_DARK | {4'd0, digit_reg};
                    wr_count  = 4'd4;
                end
            end
            sseg_pkg::MODE_CLEAR:
            begin
                ctrl_base = sseg_pkg::CTRL_RAW;
                data_byte = sseg_pkg::DP_DARK;
                wr_count  = 4'(sseg_pkg::DIGIT_COUNT);
            end
            default:
            begin
                wr_count = 4'd1;
            end
        endcase
    end

    assign bus_byte        = cmd.sel_data ? data_byte : (ctrl_base | {5'd0, wr_addr});
    assign status.no_op    = (mode > sseg_pkg::MODE_CLEAR);
    assign status.final_wr = ({1'b0, cmd.idx} == wr_count - 4'd1);

endmodule

### rtl/core/seven_segment_write_sequencer_core.sv
// Top level of the seven-segment write sequencer: joins the sequencer
// state machine (sseg_ctrl) and the byte datapath (sseg_dp). Uses sseg_pkg.
//
// A command is taken when start is high and busy is low. Each digit write
// is two transfers on consecutive cycles, the control byte with mode_pin
// high and then the data byte, so a command holds busy from the cycle
// after it is taken until its last data byte goes out; the sequencer
// state machine sets this pace. Each transfer is on bus_byte, mode_pin
// and last for one cycle with strobe high, and the receiver must take it
// then. Unused modes cause no transfer and do not raise busy.
module seven_segment_write_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [2:0]  digit_addr,
    input  logic [15:0] value,
    input  logic        dp_on,
    input  logic [1:0]  line,
    output logic        strobe,
    output logic [7:0]  bus_byte,
    output logic        mode_pin,
    output logic        last
);

    sseg_pkg::cmd_t    cmd;
    sseg_pkg::status_t status;

    sseg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .strobe   (strobe),
        .mode_pin (mode_pin),
        .last     (last)
    );

    sseg_dp u_dp (
        .clk        (clk),
        .mode       (mode),
        .digit_addr (digit_addr),
        .value      (value),
        .dp_on      (dp_on),
        .line       (line),
        .cmd        (cmd),
        .status     (status),
        .bus_byte   (bus_byte)
    );

endmodule
